// ----- rtl/min_k_timing_filter_defines.svh -----
// ---------------------------------------------------------------------------
// Minimum-K timing filter: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef MIN_K_TIMING_FILTER_DEFINES_SVH
`define MIN_K_TIMING_FILTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MKTF_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MKTF_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/mktf_pkg.sv -----
// ---------------------------------------------------------------------------
// Minimum-K timing filter: package
// Sizes, reset values, engine states and the request record shared by the
// front queue and the filter engine.
// ---------------------------------------------------------------------------
`default_nettype none

package mktf_pkg;

	localparam int SLOTS       = 10;
	localparam int DUR_W       = 32;
	localparam int TOL_W       = 8;
	localparam int KEPT_W      = 4;
	localparam int CNT_W       = $clog2(SLOTS + 1);
	localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SUM_W       = DUR_W + CNT_W;
	localparam int DIV_BITS    = 8;
	localparam int DIV_W       = ((SUM_W + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
	localparam int DIV_STEPS   = DIV_W / DIV_BITS;
	localparam int STEP_W      = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
	localparam int PROD_W      = DUR_W + TOL_W + 1;

	// The queue depth is a power of two so that the pointers wrap naturally.
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	localparam logic [TOL_W-1:0] TOL_RESET = 8'd102;

	typedef struct packed {
		logic             valid;
		logic [DUR_W-1:0] duration;
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_HI,
		ST_MUL_LO,
		ST_CHECK,
		ST_INSERT,
		ST_SUM,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/min_k_timing_filter.sv -----
// ---------------------------------------------------------------------------
// Minimum-K timing filter
// Keeps the smallest run durations within a tolerance band around their
// running average and reports the average and fill count per request.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  in       input      in_valid/in_ready    duration_us
//  out      output     out_valid/out_ready  rejected, average_us, kept_count
//  cfg      input      cfg_we               cfg_wdata (tolerance)
//
// A rejected request leaves the engine after the band check; a kept one
// goes on through sorted insertion, the serial summation over the slots and
// the five passes of the radix-256 divider.
// The front queue holds two requests while the engine is busy.
// Reset clears the slot valid bits, the average and the queue at once.
// A stalled result holds the engine in its done state; the queue still fills.
// ---------------------------------------------------------------------------
`default_nettype none

module min_k_timing_filter (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [mktf_pkg::DUR_W-1:0]  duration_us,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             rejected,
	output logic [mktf_pkg::DUR_W-1:0]       average_us,
	output logic [mktf_pkg::KEPT_W-1:0]      kept_count,
	input  wire logic                        cfg_we,
	input  wire logic [mktf_pkg::TOL_W-1:0]  cfg_wdata
);
	import mktf_pkg::*;

	logic [TOL_W-1:0] tol_q;
	req_t             req;
	logic             pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	mktf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.duration_us (duration_us),
		.req         (req),
		.pop         (pop)
	);

	mktf_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.pop        (pop),
		.tol        (tol_q),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.rejected   (rejected),
		.average_us (average_us),
		.kept_count (kept_count)
	);

endmodule

`default_nettype wire

// ----- rtl/mktf_front.sv -----
// ---------------------------------------------------------------------------
// Minimum-K timing filter: front queue
// Accepts duration requests and holds them in a short queue until the
// filter engine takes them.
// ---------------------------------------------------------------------------
`default_nettype none

module mktf_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [mktf_pkg::DUR_W-1:0] duration_us,
	output mktf_pkg::req_t                  req,
	input  wire logic                       pop
);
	import mktf_pkg::*;

	logic [DUR_W-1:0]  mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              take;

	assign in_ready     = (count_q != QCNT_W'(QDEPTH));
	assign push         = in_valid && in_ready;
	assign req.valid    = (count_q != '0);
	assign req.duration = mem_q[rd_ptr_q];
	assign take         = pop && req.valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= duration_us;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !take) begin
				count_q <= count_q + 1'b1;
			end else if (take && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/mktf_engine.sv -----
// ---------------------------------------------------------------------------
// Minimum-K timing filter: filter engine
// Band test against the running average, sorted insertion into the slot
// list, serial summation, radix-256 division and the result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "min_k_timing_filter_defines.svh"

module mktf_engine (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire mktf_pkg::req_t              req,
	output logic                             pop,
	input  wire logic [mktf_pkg::TOL_W-1:0]  tol,
	input  wire logic                        out_ready,
	output logic                             out_valid,
	output logic                             rejected,
	output logic [mktf_pkg::DUR_W-1:0]       average_us,
	output logic [mktf_pkg::KEPT_W-1:0]      kept_count
);
	import mktf_pkg::*;

	state_t             state_q;
	state_t             state_d;

	logic [DUR_W-1:0]   d_q;
	logic [DUR_W-1:0]   avg_q;
	logic [PROD_W-1:0]  hi_q;
	logic [PROD_W-1:0]  lo_q;
	logic               rej_q;
	logic [DUR_W-1:0]   slot_q [SLOTS];
	logic [SLOTS-1:0]   valid_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   idx_q;
	logic [SUM_W-1:0]   sum_q;
	logic [DIV_W-1:0]   dq_q;
	logic [CNT_W-1:0]   rem_q;
	logic [STEP_W-1:0]  step_q;
	logic               out_valid_q;
	logic               out_rej_q;
	logic [DUR_W-1:0]   out_avg_q;
	logic [KEPT_W-1:0]  out_kept_q;

	logic               load_out;
	logic [TOL_W:0]     mul_a;
	logic [PROD_W-1:0]  prod;
	logic [PROD_W-1:0]  scaled;
	logic               reject;
	logic [SLOTS-1:0]   lt;
	logic [SLOTS-1:0]   first;
	logic [DUR_W-1:0]   prev_slot [SLOTS];
	logic [SLOTS-1:0]   prev_valid;
	logic [DUR_W-1:0]   slot_n [SLOTS];
	logic [SLOTS-1:0]   valid_n;
	logic [SUM_W-1:0]   sum_n;
	logic [DIV_W-1:0]   dq_n;
	logic [CNT_W-1:0]   rem_n;
	logic               sum_last;
	logic               div_last;

	assign sum_last = (idx_q == IDX_W'(SLOTS - 1));
	assign div_last = (step_q == STEP_W'(DIV_STEPS - 1));

	// One shared multiplier forms the upper and then the lower band limit.
	assign mul_a  = (state_q == ST_MUL_HI) ? {1'b1, tol}
	                                       : ((TOL_W + 1)'(256) - {1'b0, tol});
	assign prod   = PROD_W'(mul_a) * PROD_W'(avg_q);
	assign scaled = PROD_W'({d_q, 8'h00});
	assign reject = (scaled > hi_q) || (scaled < lo_q);

	always_comb begin
		prev_slot[0]  = d_q;
		prev_valid[0] = 1'b1;
		for (int i = 1; i < SLOTS; i++) begin
			prev_slot[i]  = slot_q[i-1];
			prev_valid[i] = valid_q[i-1];
		end
		for (int i = 0; i < SLOTS; i++) begin
			lt[i] = !valid_q[i] || (d_q < slot_q[i]);
		end
		first[0] = lt[0];
		for (int i = 1; i < SLOTS; i++) begin
			first[i] = lt[i] && !lt[i-1];
		end
		for (int i = 0; i < SLOTS; i++) begin
			if (first[i]) begin
				slot_n[i]  = d_q;
				valid_n[i] = 1'b1;
			end else if (lt[i]) begin
				slot_n[i]  = prev_slot[i];
				valid_n[i] = prev_valid[i];
			end else begin
				slot_n[i]  = slot_q[i];
				valid_n[i] = valid_q[i];
			end
		end
	end

	assign sum_n = sum_q + (valid_q[idx_q] ? SUM_W'(slot_q[idx_q]) : '0);

	always_comb begin
		logic [CNT_W:0] trial;
		rem_n = rem_q;
		dq_n  = dq_q;
		for (int k = 0; k < DIV_BITS; k++) begin
			trial = {rem_n, dq_n[DIV_W-1]};
			dq_n  = {dq_n[DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, cnt_q}) begin
				rem_n   = CNT_W'(trial - {1'b0, cnt_q});
				dq_n[0] = 1'b1;
			end else begin
				rem_n   = trial[CNT_W-1:0];
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_MUL_HI;
				end
			end
			ST_MUL_HI: state_d = ST_MUL_LO;
			ST_MUL_LO: state_d = ST_CHECK;
			ST_CHECK: begin
				state_d = reject ? ST_DONE : ST_INSERT;
			end
			ST_INSERT: state_d = ST_SUM;
			ST_SUM: begin
				if (sum_last) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: pop      = req.valid;
			ST_DONE: load_out = !out_valid_q || out_ready;
			default: begin
				pop      = 1'b0;
				load_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			avg_q       <= '0;
			valid_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop && (cnt_q == '0)) begin
				avg_q <= req.duration;
			end
			if (state_q == ST_INSERT) begin
				valid_q <= valid_n;
				if ((|lt) && !valid_q[SLOTS-1]) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if ((state_q == ST_DIV) && div_last) begin
				avg_q <= dq_n[DUR_W-1:0];
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			d_q <= req.duration;
		end
		if (state_q == ST_MUL_HI) begin
			hi_q <= prod;
		end
		if (state_q == ST_MUL_LO) begin
			lo_q <= prod;
		end
		if (state_q == ST_CHECK) begin
			rej_q <= reject;
		end
		if (state_q == ST_INSERT) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_q[i] <= slot_n[i];
			end
			idx_q <= '0;
			sum_q <= '0;
		end
		if (state_q == ST_SUM) begin
			idx_q <= idx_q + 1'b1;
			sum_q <= sum_n;
			if (sum_last) begin
				dq_q   <= DIV_W'(sum_n);
				rem_q  <= '0;
				step_q <= '0;
			end
		end
		if (state_q == ST_DIV) begin
			dq_q   <= dq_n;
			rem_q  <= rem_n;
			step_q <= step_q + 1'b1;
		end
		if (load_out) begin
			out_rej_q  <= rej_q;
			out_avg_q  <= avg_q;
			out_kept_q <= KEPT_W'(cnt_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign rejected   = out_rej_q;
	assign average_us = out_avg_q;
	assign kept_count = out_kept_q;

	`MKTF_ASSERT_IMPL(a_cnt_matches, 1'b1, cnt_q == CNT_W'($countones(valid_q)), "count and valid bits disagree")
	`MKTF_ASSERT_IMPL(a_valid_prefix, 1'b1, ((valid_q >> 1) & ~valid_q) == '0, "filled slots are not a prefix")
	`MKTF_ASSERT_IMPL(a_out_from_done, $rose(out_valid_q), $past(state_q == ST_DONE), "result loaded outside the done state")
	`MKTF_ASSERT_NEXT(a_cnt_grows, state_q == ST_INSERT, cnt_q >= $past(cnt_q), "slot count fell on insertion")

endmodule

`default_nettype wire
